### hdl/ldr_nbf_pkg.sv
package ldr_nbf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 11;
    localparam int GAIN_W = 9;

    localparam logic [CFG_DW-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [CFG_DW-1:0] HEIGHT_RST = 11'd768;

    localparam int FULL_SCALE = 5 * 5 * 255 * 3 * 255;
    localparam int WIN_TAPS   = 25;
    localparam int EDGE       = 2;

    localparam logic MODE_PIXEL = 1'b0;

    typedef enum logic [CFG_AW-1:0] {
        REG_GAIN   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

endpackage

### hdl/ldr_in_if.sv
interface ldr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] opacity;

    modport source (output valid, mode, blue, green, red, opacity, input ready);
    modport sink (input valid, mode, blue, green, red, opacity, output ready);
endinterface

### hdl/ldr_out_if.sv
interface ldr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_opacity;
    logic       last_pixel;

    modport source (output valid, out_blue, out_green, out_red, out_opacity, last_pixel,
                    input ready);
    modport sink (input valid, out_blue, out_green, out_red, out_opacity, last_pixel,
                  output ready);
endinterface

### hdl/ldr_cfg_if.sv
interface ldr_cfg_if import ldr_nbf_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/ldr_nbf_queue.sv
module ldr_nbf_queue import ldr_nbf_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             nonempty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTW-1:0]   wr_ptr_reg;
    logic [PTW-1:0]   rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/ldr_nbf_front.sv
module ldr_nbf_front import ldr_nbf_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int AW = $clog2(4 * MAX_WIDTH + 8),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int EW = 3 * AW + WW + 36
) (
    input  logic              clk,
    input  logic              rst_n,
    ldr_in_if.sink            pix_in,
    input  logic [CFG_DW-1:0] width_cfg,
    input  logic [CFG_DW-1:0] height_cfg,
    input  logic              q_full,
    output logic              q_push,
    output logic [EW-1:0]     q_data
);

    localparam int RING = 4 * MAX_WIDTH + 8;
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int PW   = $clog2(2 * MAX_WIDTH + 3);

    typedef struct packed {
        logic          wr;
        logic [AW-1:0] waddr;
        logic [31:0]   pixel;
        logic          emit;
        logic [AW-1:0] caddr;
        logic [AW-1:0] taddr;
        logic          interior;
        logic          last;
        logic [WW-1:0] fw;
    } entry_t;

    logic [WW-1:0] frame_w_reg;
    logic [HW-1:0] frame_h_reg;
    logic [HW-1:0] in_row_reg;
    logic [WW-1:0] in_col_reg;
    logic [HW-1:0] out_row_reg;
    logic [WW-1:0] out_col_reg;
    logic [PW-1:0] pend_reg;
    logic [AW-1:0] wptr_reg;
    logic [AW-1:0] optr_reg;

    logic          accept;
    logic          is_pix;
    logic          start;
    logic [WW-1:0] clamp_w;
    logic [HW-1:0] clamp_h;
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          in_done;
    logic [PW-1:0] thr;
    logic          wr;
    logic          emit;
    logic          last;
    logic          interior;
    logic [AW:0]   tl_sum;
    logic [AW-1:0] tl_addr;
    entry_t        ent;

    assign pix_in.ready = !q_full;
    assign accept       = pix_in.valid && pix_in.ready;
    assign is_pix       = (pix_in.mode == MODE_PIXEL);
    assign start        = is_pix && (in_row_reg == '0) && (in_col_reg == '0)
                          && (out_row_reg == '0) && (out_col_reg == '0);

    always_comb
    begin
        if (width_cfg == '0)
        begin
            clamp_w = WW'(1);
        end
        else if (32'(width_cfg) > 32'(MAX_WIDTH))
        begin
            clamp_w = WW'(MAX_WIDTH);
        end
        else
        begin
            clamp_w = WW'(width_cfg);
        end
        if (height_cfg == '0)
        begin
            clamp_h = HW'(1);
        end
        else if (32'(height_cfg) > 32'(MAX_HEIGHT))
        begin
            clamp_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            clamp_h = HW'(height_cfg);
        end
    end

    assign eff_w   = start ? clamp_w : frame_w_reg;
    assign eff_h   = start ? clamp_h : frame_h_reg;
    assign in_done = (in_row_reg >= eff_h);
    assign thr     = PW'({eff_w, 1'b0}) + PW'(2);
    assign wr      = !in_done && is_pix;
    assign emit    = in_done ? (pend_reg != '0) : (is_pix && (pend_reg >= thr));
    assign last    = (out_row_reg == eff_h - HW'(1)) && (out_col_reg == eff_w - WW'(1));
    assign interior = (out_row_reg >= HW'(EDGE)) && (out_col_reg >= WW'(EDGE))
                      && ({1'b0, out_row_reg} + (HW+1)'(EDGE) < {1'b0, eff_h})
                      && ({1'b0, out_col_reg} + (WW+1)'(EDGE) < {1'b0, eff_w});

    assign tl_sum  = {1'b0, optr_reg} + (AW+1)'(RING) - (AW+1)'(thr);
    assign tl_addr = (tl_sum >= (AW+1)'(RING)) ? AW'(tl_sum - (AW+1)'(RING)) : AW'(tl_sum);

    always_comb
    begin
        ent.wr       = wr;
        ent.waddr    = wptr_reg;
        ent.pixel    = {pix_in.opacity, pix_in.red, pix_in.green, pix_in.blue};
        ent.emit     = emit;
        ent.caddr    = optr_reg;
        ent.taddr    = tl_addr;
        ent.interior = interior;
        ent.last     = last;
        ent.fw       = eff_w;
    end

    assign q_data = ent;
    assign q_push = accept && (wr || emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg <= WW'(1);
            frame_h_reg <= HW'(1);
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            pend_reg    <= '0;
            wptr_reg    <= '0;
            optr_reg    <= '0;
        end
        else if (accept)
        begin
            if (start)
            begin
                frame_w_reg <= clamp_w;
                frame_h_reg <= clamp_h;
            end
            if (emit && last)
            begin
                in_row_reg  <= '0;
                in_col_reg  <= '0;
                out_row_reg <= '0;
                out_col_reg <= '0;
                pend_reg    <= '0;
                wptr_reg    <= '0;
                optr_reg    <= '0;
            end
            else
            begin
                if (wr)
                begin
                    wptr_reg <= (wptr_reg == AW'(RING - 1)) ? '0 : wptr_reg + 1'b1;
                    if (in_col_reg == eff_w - WW'(1))
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + 1'b1;
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                end
                if (emit)
                begin
                    optr_reg <= (optr_reg == AW'(RING - 1)) ? '0 : optr_reg + 1'b1;
                    if (out_col_reg == eff_w - WW'(1))
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
                if (wr && !emit)
                begin
                    pend_reg <= pend_reg + 1'b1;
                end
                else if (emit && !wr)
                begin
                    pend_reg <= pend_reg - 1'b1;
                end
            end
        end
    end

endmodule

### hdl/ldr_nbf_back.sv
module ldr_nbf_back import ldr_nbf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int AW = $clog2(4 * MAX_WIDTH + 8),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int EW = 3 * AW + WW + 36
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  logic [EW-1:0]     q_data,
    input  logic [GAIN_W-1:0] gain,
    ldr_out_if.source         pix_out
);

    localparam int RING   = 4 * MAX_WIDTH + 8;
    localparam int RSHIFT = 54;
    localparam logic [31:0] RECIP =
        32'(((64'd1 << RSHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));
    localparam logic [30:0] ROUND_UP = 31'(FULL_SCALE - 1);

    typedef struct packed {
        logic          wr;
        logic [AW-1:0] waddr;
        logic [31:0]   pixel;
        logic          emit;
        logic [AW-1:0] caddr;
        logic [AW-1:0] taddr;
        logic          interior;
        logic          last;
        logic [WW-1:0] fw;
    } entry_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_DRAIN = 7'b0000100,
        ST_SCALE = 7'b0001000,
        ST_PROD  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    logic [31:0] mem [RING];

    state_t               state_reg;
    state_t               state_next;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        tl_reg;
    logic [WW-1:0]        fw_reg;
    logic                 interior_reg;
    logic                 last_reg;
    logic [4:0]           cnt_reg;
    logic [2:0]           dc_reg;
    logic [31:0]          rdata_reg;
    logic                 rv_reg;
    logic                 rv_center_reg;
    logic [31:0]          pixel_reg;
    logic [14:0]          sum_reg;
    logic signed [24:0]   sg_reg;
    logic                 neg_reg;
    logic [30:0]          mag_reg [3];
    logic [8:0]           q_reg [3];
    logic                 ov_reg;
    logic [7:0]           res_reg [3];
    logic [7:0]           res_op_reg;
    logic                 res_last_reg;

    entry_t               ent;
    logic                 read_last;
    logic [AW:0]          step_sum;
    logic [AW-1:0]        step_addr;
    logic signed [24:0]   sg_full;
    logic signed [33:0]   prod [3];
    logic [62:0]          scaled [3];
    logic [7:0]           chan_val [3];
    logic                 out_free;

    assign ent       = entry_t'(q_data);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_free  = !ov_reg || pix_out.ready;
    assign read_last = ((cnt_reg == '0) && !interior_reg) || (cnt_reg == 5'(WIN_TAPS));
    assign step_sum  = {1'b0, addr_reg}
                       + ((dc_reg == 3'd4) ? (AW+1)'(fw_reg - WW'(4)) : (AW+1)'(1));
    assign step_addr = (step_sum >= (AW+1)'(RING)) ? AW'(step_sum - (AW+1)'(RING))
                                                   : AW'(step_sum);
    assign sg_full   = $signed({1'b0, sum_reg}) * $signed(gain);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [9:0]  qv;
            logic signed [10:0] v;
            qv        = neg_reg ? -$signed({1'b0, q_reg[i]}) : $signed({1'b0, q_reg[i]});
            v         = $signed({3'b000, pixel_reg[8*i +: 8]}) + 11'(qv);
            prod[i]   = sg_reg * $signed({1'b0, pixel_reg[8*i +: 8]});
            scaled[i] = {32'b0, mag_reg[i]} * {31'b0, RECIP};
            if (!interior_reg)
            begin
                chan_val[i] = pixel_reg[8*i +: 8];
            end
            else if (v < 0)
            begin
                chan_val[i] = 8'd0;
            end
            else if (v > 11'sd255)
            begin
                chan_val[i] = 8'd255;
            end
            else
            begin
                chan_val[i] = v[7:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_pop && ent.emit) state_next = ST_READ;
            ST_READ:  if (read_last) state_next = ST_DRAIN;
            ST_DRAIN: state_next = interior_reg ? ST_SCALE : ST_EMIT;
            ST_SCALE: state_next = ST_PROD;
            ST_PROD:  state_next = ST_DIV;
            ST_DIV:   state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && ent.wr)
        begin
            mem[ent.waddr] <= ent.pixel;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            addr_reg     <= ent.caddr;
            tl_reg       <= ent.taddr;
            fw_reg       <= ent.fw;
            interior_reg <= ent.interior;
            last_reg     <= ent.last;
            cnt_reg      <= '0;
            dc_reg       <= '0;
            sum_reg      <= '0;
        end
        else if (state_reg == ST_READ)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == '0)
            begin
                addr_reg <= tl_reg;
                dc_reg   <= '0;
            end
            else
            begin
                addr_reg <= step_addr;
                dc_reg   <= (dc_reg == 3'd4) ? 3'd0 : dc_reg + 1'b1;
            end
        end
        rv_center_reg <= (cnt_reg == '0);
        if (rv_reg)
        begin
            if (rv_center_reg)
            begin
                pixel_reg <= rdata_reg;
            end
            else
            begin
                sum_reg <= sum_reg + 15'(rdata_reg[7:0]) + 15'(rdata_reg[15:8])
                           + 15'(rdata_reg[23:16]);
            end
        end
        if (state_reg == ST_SCALE)
        begin
            sg_reg <= sg_full;
        end
        if (state_reg == ST_PROD)
        begin
            neg_reg <= sg_reg < 0;
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= 31'((prod[i] < 0) ? -prod[i] : prod[i])
                              + ((sg_reg < 0) ? ROUND_UP : 31'd0);
            end
        end
        if (state_reg == ST_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q_reg[i] <= scaled[i][RSHIFT+8:RSHIFT];
            end
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= chan_val[i];
            end
            res_op_reg   <= pixel_reg[31:24];
            res_last_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= (state_reg == ST_READ);
            if ((state_reg == ST_EMIT) && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign pix_out.valid       = ov_reg;
    assign pix_out.out_blue    = res_reg[0];
    assign pix_out.out_green   = res_reg[1];
    assign pix_out.out_red     = res_reg[2];
    assign pix_out.out_opacity = res_op_reg;
    assign pix_out.last_pixel  = res_last_reg;

endmodule

### hdl/ldr_neighbourhood_brightness_filter.sv
// 5x5 neighbourhood brightness filter on a raster stream of BGRA pixels.
// pix_in carries one beat per item: mode 0 is a pixel, mode 1 a flush beat.
// pix_out carries one filtered pixel per beat, last_pixel marks the
// bottom-right pixel of the frame. cfg writes gain, width and height by
// index; it is always ready; write it only while the block is idle, as the
// block does not enforce this. Results lag the input by two rows and two
// pixels; after the last pixel of a frame, flush beats (or further pixel
// beats, whose data is dropped) drain the pending results one per beat.
// The front accepts one beat per cycle while its two-entry queue has room.
// The back takes one queue entry per cycle when no result is due; an entry
// with a result holds it until the result is in the output register: centre
// read, drain and output states for a border result; for an interior one,
// 26 line store reads at one per cycle, a drain state, two multiply steps, a
// reciprocal multiply and the output state. Throughput is bounded by the back.
// Reset clears all positions and the output valid register; the line store
// holds no reset value and is always written before it is read.
// When pix_out stalls, the result is held; the back stops and the queue
// fills, after which pix_in drops ready.
module ldr_neighbourhood_brightness_filter import ldr_nbf_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ldr_in_if.sink     pix_in,
    ldr_out_if.source  pix_out,
    ldr_cfg_if.sink    cfg
);

    localparam int AW = $clog2(4 * MAX_WIDTH + 8);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = 3 * AW + WW + 36;

    logic [GAIN_W-1:0] gain_reg;
    logic [CFG_DW-1:0] width_reg;
    logic [CFG_DW-1:0] height_reg;

    logic          q_push;
    logic [EW-1:0] q_push_data;
    logic          q_full;
    logic          q_pop;
    logic [EW-1:0] q_pop_data;
    logic          q_nonempty;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= '0;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_GAIN:   gain_reg   <= cfg.data[GAIN_W-1:0];
                REG_WIDTH:  width_reg  <= cfg.data;
                REG_HEIGHT: height_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    ldr_nbf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_push_data)
    );

    ldr_nbf_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .nonempty  (q_nonempty)
    );

    ldr_nbf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_nonempty),
        .q_pop   (q_pop),
        .q_data  (q_pop_data),
        .gain    (gain_reg),
        .pix_out (pix_out)
    );

endmodule
